/* design/htmks_pkg.sv */
package htmks_pkg;

    localparam int unsigned TIMER_W = 16;
    localparam logic [TIMER_W-1:0] WAIT_TICKS_RESET = 16'd1000;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_WAIT_TICKS = 3'd0;

    // scan phase codes
    localparam logic [2:0] PH_SCAN     = 3'd0;
    localparam logic [2:0] PH_DEBOUNCE = 3'd1;
    localparam logic [2:0] PH_HOLD1    = 3'd2;
    localparam logic [2:0] PH_HOLD2    = 3'd3;
    localparam logic [2:0] PH_RELDEB   = 3'd4;
    localparam logic [2:0] PH_RELEASE  = 3'd5;

    localparam logic [1:0] ROW_D   = 2'd3;
    localparam logic [1:0] COL_1   = 2'd0;
    localparam logic [1:0] COL_2   = 2'd1;
    localparam logic [1:0] COL_4   = 2'd3;

    typedef struct packed {
        logic [1:0]         scan_row;
        logic [1:0]         scan_column;
        logic [2:0]         phase;
        logic [TIMER_W-1:0] interval_timer;
        logic [1:0]         hold_count;
    } t_scan_state;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [7:0] key_code;
        logic       clear_pulse;
    } t_result;

    // Character for a key position (row*4+col) and clamped hold count.
    function automatic logic [7:0] key_char(input logic [3:0] pos, input logic [1:0] hold);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        begin
            case (pos)
                4'd0:    begin c0 = "7"; c1 = "A"; c2 = "B"; end
                4'd1:    begin c0 = "8"; c1 = "C"; c2 = "D"; end
                4'd2:    begin c0 = "9"; c1 = "E"; c2 = "F"; end
                4'd3:    begin c0 = "/"; c1 = "G"; c2 = "H"; end
                4'd4:    begin c0 = "4"; c1 = "I"; c2 = "J"; end
                4'd5:    begin c0 = "5"; c1 = "K"; c2 = "L"; end
                4'd6:    begin c0 = "6"; c1 = "M"; c2 = "N"; end
                4'd7:    begin c0 = "*"; c1 = "O"; c2 = "P"; end
                4'd8:    begin c0 = "1"; c1 = "Q"; c2 = "R"; end
                4'd9:    begin c0 = "2"; c1 = "S"; c2 = "T"; end
                4'd10:   begin c0 = "3"; c1 = "U"; c2 = "V"; end
                4'd11:   begin c0 = "-"; c1 = "W"; c2 = "X"; end
                4'd13:   begin c0 = "0"; c1 = "Y"; c2 = "Z"; end
                4'd14:   begin c0 = "="; c1 = "="; c2 = "="; end
                4'd15:   begin c0 = "+"; c1 = "+"; c2 = "+"; end
                default: begin c0 = 8'd0; c1 = 8'd0; c2 = 8'd0; end
            endcase
            case (hold)
                2'd0:    key_char = c0;
                2'd1:    key_char = c1;
                default: key_char = c2;
            endcase
        end
    endfunction

endpackage

/* design/htmks_in_if.sv */
interface htmks_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] column_lines;

    modport source (output valid, output column_lines, input ready);
    modport sink (input valid, input column_lines, output ready);
endinterface

/* design/htmks_out_if.sv */
interface htmks_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_drive;
    logic       key_valid;
    logic [7:0] key_code;
    logic       clear_pulse;

    modport source (output valid, output row_drive, output key_valid, output key_code,
                    output clear_pulse, input ready);
    modport sink (input valid, input row_drive, input key_valid, input key_code,
                  input clear_pulse, output ready);
endinterface

/* design/htmks_step.sv */
module htmks_step
    import htmks_pkg::*;
(
    input  t_scan_state        i_state,
    input  logic [3:0]         i_cols,
    input  logic [TIMER_W-1:0] i_wait_ticks,
    output t_scan_state        o_state,
    output t_result            o_result
);

    logic [1:0] row;
    logic [1:0] col;
    logic       low;
    logic       timing;
    logic       emit;
    logic [1:0] emit_hold;

    assign row    = i_state.scan_row;
    assign col    = i_state.scan_column;
    assign low    = ~i_cols[col];
    assign timing = (i_state.phase == PH_DEBOUNCE || i_state.phase == PH_HOLD1 ||
                     i_state.phase == PH_HOLD2 || i_state.phase == PH_RELDEB) &&
                    (i_state.interval_timer != '0);

    always_comb begin
        o_state   = i_state;
        emit      = 1'b0;
        emit_hold = i_state.hold_count;
        o_result.row_drive   = ~(4'b0001 << row);
        o_result.clear_pulse = 1'b0;

        if (timing) begin
            o_state.interval_timer = i_state.interval_timer - 1'b1;
        end else begin
            case (i_state.phase)
                PH_DEBOUNCE: begin
                    if (low) begin
                        o_state.hold_count     = 2'd1;
                        o_state.interval_timer = i_wait_ticks;
                        o_state.phase          = PH_HOLD1;
                    end else begin
                        o_state.hold_count = 2'd0;
                        emit_hold          = 2'd0;
                        emit               = 1'b1;
                    end
                end
                PH_HOLD1: begin
                    if (low) begin
                        o_state.hold_count     = 2'd2;
                        o_state.interval_timer = i_wait_ticks;
                        o_state.phase          = PH_HOLD2;
                    end else begin
                        emit = 1'b1;
                    end
                end
                PH_HOLD2: begin
                    emit = 1'b1;
                end
                PH_RELDEB: begin
                    o_state.phase = PH_RELEASE;
                end
                PH_RELEASE: begin
                    if (!low) begin
                        if (col == COL_1) begin
                            // clear key: resume at row D column 2
                            o_result.clear_pulse = 1'b1;
                            o_state.scan_column  = COL_2;
                            o_state.phase        = PH_SCAN;
                        end else begin
                            o_state.hold_count = 2'd0;
                            emit_hold          = 2'd0;
                            emit               = 1'b1;
                        end
                    end
                end
                default: begin
                    o_state.phase = PH_SCAN;
                    if (low) begin
                        o_state.interval_timer = i_wait_ticks;
                        o_state.phase = (row == ROW_D && col != COL_2) ? PH_RELDEB
                                                                       : PH_DEBOUNCE;
                    end else if (col == COL_4) begin
                        o_state.scan_column = COL_1;
                        o_state.scan_row    = row + 1'b1;
                    end else begin
                        o_state.scan_column = col + 1'b1;
                    end
                end
            endcase
        end

        if (emit) begin
            o_state.scan_row    = 2'd0;
            o_state.scan_column = COL_1;
            o_state.phase       = PH_SCAN;
        end
        o_result.key_valid = emit;
        o_result.key_code  = emit ? key_char({row, col}, (emit_hold == 2'd3) ? 2'd2 : emit_hold)
                                  : 8'd0;
    end

endmodule

/* design/hold_time_multitap_keypad_scanner.sv */
// Path: a column beat accepted on the input channel is held in the input register, then
//   passes the scan step into the result register (one input register, one result register).
// Throughput: one beat per cycle while the output channel is ready; the scan step between
//   the two registers is a single pass of short logic, so a tick may enter in every such cycle.
// Reset (i_rst_n low, synchronous): scan at row A column 1, idle phase, timer and
//   hold count zero, wait_ticks back to 1000, both pipeline stages empty.
module hold_time_multitap_keypad_scanner
    import htmks_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // column ticks in, scan results out
    htmks_in_if.sink           i_col_ch,
    htmks_out_if.source        o_key_ch
);

    logic [TIMER_W-1:0] r_wait_ticks;
    t_scan_state        r_state;
    t_scan_state        n_state;
    t_result            step_result;

    logic               r_s1_valid;
    logic [3:0]         r_s1_cols;
    logic               r_out_valid;
    t_result            r_out;

    logic               advance;
    logic               in_take;

    // Register file: a single register, write on the access phase.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WAIT_TICKS) ? {16'd0, r_wait_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= WAIT_TICKS_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_WAIT_TICKS) begin
            r_wait_ticks <= pwdata[TIMER_W-1:0];
        end
    end

    // Advance the held tick into the result register whenever that register is
    // free or its beat leaves this cycle; take a new tick whenever the input
    // stage is empty or advancing.
    assign advance          = r_s1_valid && (!r_out_valid || o_key_ch.ready);
    assign i_col_ch.ready   = !r_s1_valid || advance;
    assign in_take          = i_col_ch.valid && i_col_ch.ready;

    htmks_step u_step (
        .i_state      (r_state),
        .i_cols       (r_s1_cols),
        .i_wait_ticks (r_wait_ticks),
        .o_state      (n_state),
        .o_result     (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{scan_row: 2'd0, scan_column: COL_1, phase: PH_SCAN,
                             interval_timer: '0, hold_count: 2'd0};
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_key_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cols <= i_col_ch.column_lines;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_key_ch.valid       = r_out_valid;
    assign o_key_ch.row_drive   = r_out.row_drive;
    assign o_key_ch.key_valid   = r_out.key_valid;
    assign o_key_ch.key_code    = r_out.key_code;
    assign o_key_ch.clear_pulse = r_out.clear_pulse;

endmodule
